// ===== design/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg
// shared types and constants of the integer matrix multiply core
// ----------------------------------------------------------------------------
package imm_pkg;

    localparam int FIELD_SPAN  = 8;
    localparam int IDX_W       = 3;
    localparam int SIZE_W      = 4;
    localparam int WORD_W      = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [WORD_W-1:0] value;
    } cmd_t;

endpackage

// ===== design/integer_matrix_multiply_core.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply_core
// square signed 32-bit matrix multiplier with element load and compute
// ----------------------------------------------------------------------------
// Load transactions write one element of A or B and retire in one cycle each
// once they reach the engine; a four-entry command queue sits between the
// input stage and the engine. A compute transaction emits the n*n elements of
// C = A*B in row-major order, marking the final one with last. Each element
// is formed by the single multiply-accumulate unit reading one word per cycle
// from each store, then passes two pipeline stages and the output register;
// the next element starts only once it is in that register. Arithmetic wraps
// modulo 2^32. matrix_size is sampled when a compute starts.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_core #(
    parameter int MAX_N = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [imm_pkg::SIZE_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         operation,
    input  logic [imm_pkg::IDX_W-1:0]          row,
    input  logic [imm_pkg::IDX_W-1:0]          col,
    input  logic signed [imm_pkg::WORD_W-1:0]  value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [imm_pkg::IDX_W-1:0]          row_res,
    output logic [imm_pkg::IDX_W-1:0]          col_res,
    output logic signed [imm_pkg::WORD_W-1:0]  value_res,
    output logic                               last
);

    logic [imm_pkg::SIZE_W-1:0] matrix_size_reg;
    logic                       push, full, pop, pop_valid;
    imm_pkg::cmd_t              push_cmd, pop_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_size_reg <= imm_pkg::SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            matrix_size_reg <= cfg_data;
        end
    end

    imm_front #(
        .MAX_N (MAX_N)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .row       (row),
        .col       (col),
        .value     (value),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full)
    );

    imm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    imm_back #(
        .MAX_N (MAX_N)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (pop_valid),
        .cmd         (pop_cmd),
        .cmd_pop     (pop),
        .matrix_size (matrix_size_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_res     (row_res),
        .col_res     (col_res),
        .value_res   (value_res),
        .last        (last)
    );

endmodule

// ===== design/imm_ram.sv =====
// ----------------------------------------------------------------------------
// imm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/imm_fifo.sv =====
// ----------------------------------------------------------------------------
// imm_fifo
// short command queue between the front end and the compute engine
// ----------------------------------------------------------------------------
module imm_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  imm_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output imm_pkg::cmd_t pop_cmd
);

    localparam int DEPTH = imm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    imm_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == (PTR_W+1)'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/imm_front.sv =====
// ----------------------------------------------------------------------------
// imm_front
// input stage: accepts transactions, drops ones with no effect, feeds the queue
// ----------------------------------------------------------------------------
module imm_front #(
    parameter int MAX_N = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          operation,
    input  logic [imm_pkg::IDX_W-1:0]           row,
    input  logic [imm_pkg::IDX_W-1:0]           col,
    input  logic signed [imm_pkg::WORD_W-1:0]   value,
    output logic                                push,
    output imm_pkg::cmd_t                       push_cmd,
    input  logic                                full
);

    logic          stage_valid_reg, stage_valid_next;
    imm_pkg::cmd_t stage_cmd_reg, stage_cmd_next;
    logic          is_load, in_grid, keep, advance;

    assign in_stall = stage_valid_reg && full;
    assign advance  = !in_stall;
    assign push     = stage_valid_reg && !full;
    assign push_cmd = stage_cmd_reg;

    always_comb
    begin
        is_load = (operation == imm_pkg::OP_LOAD_A) || (operation == imm_pkg::OP_LOAD_B);
        in_grid = (int'(row) < MAX_N) && (int'(col) < MAX_N);
        keep    = (is_load && in_grid) || (operation == imm_pkg::OP_COMPUTE);

        stage_valid_next     = stage_valid_reg;
        stage_cmd_next       = stage_cmd_reg;
        if (advance)
        begin
            stage_valid_next     = in_valid && keep;
            stage_cmd_next.op    = imm_pkg::op_t'(operation);
            stage_cmd_next.row   = row;
            stage_cmd_next.col   = col;
            stage_cmd_next.value = $unsigned(value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_cmd_reg <= stage_cmd_next;
    end

endmodule

// ===== design/imm_back.sv =====
// ----------------------------------------------------------------------------
// imm_back
// compute engine: writes loads into the stores, runs the multiply-accumulate
// sequencer and holds the result output register
// ----------------------------------------------------------------------------
module imm_back #(
    parameter int MAX_N = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    input  imm_pkg::cmd_t                      cmd,
    output logic                               cmd_pop,
    input  logic [imm_pkg::SIZE_W-1:0]         matrix_size,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [imm_pkg::IDX_W-1:0]          row_res,
    output logic [imm_pkg::IDX_W-1:0]          col_res,
    output logic signed [imm_pkg::WORD_W-1:0]  value_res,
    output logic                               last
);

    localparam int CAP   = (MAX_N < imm_pkg::FIELD_SPAN) ? MAX_N : imm_pkg::FIELD_SPAN;
    localparam int DEPTH = MAX_N * MAX_N;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = imm_pkg::IDX_W;
    localparam int SW    = imm_pkg::SIZE_W;
    localparam int WW    = imm_pkg::WORD_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   i_reg, i_next;
    logic [IW-1:0]   j_reg, j_next;
    logic [IW-1:0]   k_reg, k_next;
    logic [IW-1:0]   n_last_reg, n_last_next;
    logic            s1_valid_reg, s1_first_reg, s1_lastk_reg;
    logic            s2_valid_reg, s2_first_reg, s2_lastk_reg;
    logic [WW-1:0]   prod_reg, acc_reg;
    logic            out_valid_reg;
    logic [IW-1:0]   out_row_reg, out_col_reg;
    logic [WW-1:0]   out_value_reg;
    logic            out_last_reg;

    logic [SW-1:0]   n_sel, n_m1;
    logic            wr_a, wr_b, rd_en, out_load;
    logic [AW-1:0]   wr_addr, rd_addr_a, rd_addr_b;
    logic [WW-1:0]   a_rd, b_rd, prod_next;

    // size in use: zero acts as one, larger values saturate
    always_comb
    begin
        if (matrix_size == '0)
        begin
            n_sel = SW'(1);
        end
        else if (int'(matrix_size) > CAP)
        begin
            n_sel = SW'(CAP);
        end
        else
        begin
            n_sel = matrix_size;
        end
        n_m1 = n_sel - SW'(1);
    end

    assign wr_addr   = AW'(int'(cmd.row) * MAX_N + int'(cmd.col));
    assign rd_addr_a = AW'(int'(i_reg) * MAX_N + int'(k_reg));
    assign rd_addr_b = AW'(int'(k_reg) * MAX_N + int'(j_reg));

    imm_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (wr_addr),
        .wr_data (cmd.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_a),
        .rd_data (a_rd)
    );

    imm_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (wr_addr),
        .wr_data (cmd.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_b),
        .rd_data (b_rd)
    );

    assign prod_next = a_rd * b_rd;

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        n_last_next = n_last_reg;
        cmd_pop     = 1'b0;
        wr_a        = 1'b0;
        wr_b        = 1'b0;
        rd_en       = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        imm_pkg::OP_LOAD_A:
                        begin
                            wr_a = 1'b1;
                        end
                        imm_pkg::OP_LOAD_B:
                        begin
                            wr_b = 1'b1;
                        end
                        imm_pkg::OP_COMPUTE:
                        begin
                            i_next      = '0;
                            j_next      = '0;
                            k_next      = '0;
                            n_last_next = n_m1[IW-1:0];
                            state_next  = ST_ISSUE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ISSUE:
            begin
                rd_en = 1'b1;
                if (k_reg == n_last_reg)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (s2_valid_reg && s2_lastk_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load = 1'b1;
                    if (j_reg == n_last_reg)
                    begin
                        j_next = '0;
                        if (i_reg == n_last_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + IW'(1);
                            state_next = ST_ISSUE;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + IW'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            n_last_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s1_first_reg  <= 1'b0;
            s1_lastk_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_first_reg  <= 1'b0;
            s2_lastk_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            n_last_reg   <= n_last_next;
            s1_valid_reg <= rd_en;
            s1_first_reg <= (k_reg == '0);
            s1_lastk_reg <= (k_reg == n_last_reg);
            s2_valid_reg <= s1_valid_reg;
            s2_first_reg <= s1_first_reg;
            s2_lastk_reg <= s1_lastk_reg;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (s2_valid_reg)
        begin
            acc_reg <= s2_first_reg ? prod_reg : acc_reg + prod_reg;
        end
        if (out_load)
        begin
            out_row_reg   <= i_reg;
            out_col_reg   <= j_reg;
            out_value_reg <= acc_reg;
            out_last_reg  <= (i_reg == n_last_reg) && (j_reg == n_last_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign row_res   = out_row_reg;
    assign col_res   = out_col_reg;
    assign value_res = $signed(out_value_reg);
    assign last      = out_last_reg;

`ifndef SYNTHESIS
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == ST_IDLE))
        else $error("command popped while engine busy");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !((wr_a || wr_b) && rd_en))
        else $error("store write during product read");

    a_pipe_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (state_reg == ST_ISSUE || state_reg == ST_DRAIN))
        else $error("multiply pipeline active outside a dot product");

    a_drain_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && s2_valid_reg && s2_lastk_reg) |=> (state_reg == ST_EMIT))
        else $error("finished dot product not emitted");

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (k_reg <= n_last_reg))
        else $error("inner index beyond matrix size");
`endif

endmodule
